[src/rewindable_sample_ring_buffer_defines.svh]
// Assertion macros shared by the ring buffer modules.
// They expect signals named clk and arst_n in the module that uses them.
`ifndef REWINDABLE_SAMPLE_RING_BUFFER_DEFINES_SVH
`define REWINDABLE_SAMPLE_RING_BUFFER_DEFINES_SVH

// The condition holds at every clock edge outside reset.
`define RSRB_ASSERT(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("rsrb: invariant violated");

// When the antecedent holds, the consequent holds in the next cycle.
`define RSRB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rsrb: sequence violated");

`endif

[src/rsrb_pkg.sv]
`timescale 1ns / 1ps
package rsrb_pkg;

	localparam int CMD_W    = 3;
	localparam int SAMPLE_W = 16;
	localparam int AMT_W    = 12;
	localparam int CAP_W    = 11;
	localparam int CAP_RESET = 1024;

	localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ADD     = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DISCARD = 3'd4;
	localparam logic [CMD_W-1:0] CMD_REWIND  = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SHIFT   = 3'd6;
	localparam logic [CMD_W-1:0] CMD_STATUS  = 3'd7;

	// Everything the response stage needs about one command, apart from store data.
	typedef struct packed {
		logic             err;
		logic             rd_mem;
		logic             zero;
		logic [CAP_W-1:0] available;
		logic             is_empty;
		logic             is_full;
	} rsp_info_t;

endpackage

[src/rsrb_store.sv]
`timescale 1ns / 1ps
module rsrb_store #(
	parameter int MAX_DEPTH = 1024,
	localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic                              re,
	input  logic [AW-1:0]                     addr,
	input  logic [rsrb_pkg::SAMPLE_W-1:0]     wdata,
	output logic [rsrb_pkg::SAMPLE_W-1:0]     rdata
);

	logic [rsrb_pkg::SAMPLE_W-1:0] mem [MAX_DEPTH];
	logic [rsrb_pkg::SAMPLE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

[src/rsrb_ctrl.sv]
`timescale 1ns / 1ps
`include "rewindable_sample_ring_buffer_defines.svh"
module rsrb_ctrl #(
	parameter int MAX_DEPTH = 1024,
	localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [rsrb_pkg::CAP_W-1:0]            cfg_wr_data,
	input  logic                                  in_valid,
	input  logic                                  can_issue,
	input  logic [rsrb_pkg::CMD_W-1:0]            command,
	input  logic signed [rsrb_pkg::SAMPLE_W-1:0]  sample_in,
	input  logic signed [rsrb_pkg::AMT_W-1:0]     amount,
	output logic                                  issue,
	output rsrb_pkg::rsp_info_t                   info,
	output logic                                  mem_we,
	output logic                                  mem_re,
	output logic [AW-1:0]                         mem_addr,
	output logic [rsrb_pkg::SAMPLE_W-1:0]         mem_wdata
);

	localparam int CW = rsrb_pkg::CAP_W;
	localparam int MW = rsrb_pkg::AMT_W;
	localparam int WW = ((AW > CW) ? AW : CW) + 2;
	localparam int CAP_RST = (rsrb_pkg::CAP_RESET > MAX_DEPTH) ? MAX_DEPTH : rsrb_pkg::CAP_RESET;

	logic [CW-1:0] cap_q;
	logic [AW-1:0] rd_q;
	logic [AW-1:0] wr_q;
	logic          empty_q;
	// Entries 0 .. fill_q-1 have been written since the last clear; the rest read as zero.
	logic [CW-1:0] fill_q;

	logic [WW-1:0] cap_w, rd_w, wr_w, fill_w;
	logic [WW-1:0] amt_ext, amt_mag, avail_cur, avail_new;
	logic [WW-1:0] rd_n, wr_n, fill_n, fwd_w, addr_w, cfg_w;
	logic          amt_neg, amt_zero, empty_n, err, we_c, re_c;
	logic [CW-1:0] cap_limited;

	function automatic logic [WW-1:0] wrap_f(input logic [WW-1:0] p, input logic [WW-1:0] c);
		return (p >= c) ? p - c : p;
	endfunction

	function automatic logic [WW-1:0] avail_f(input logic [WW-1:0] r, input logic [WW-1:0] w,
			input logic e, input logic [WW-1:0] c);
		logic [WW-1:0] res;
		if (w > r) begin
			res = w - r;
		end else if (w < r) begin
			res = c + w - r;
		end else begin
			res = e ? '0 : c;
		end
		return res;
	endfunction

	assign cap_w   = WW'(cap_q);
	assign rd_w    = WW'(rd_q);
	assign wr_w    = WW'(wr_q);
	assign fill_w  = WW'(fill_q);
	assign amt_neg = amount[MW-1];
	assign amt_ext = {{(WW-MW){amount[MW-1]}}, amount};
	assign amt_mag = amt_neg ? (WW'(0) - amt_ext) : amt_ext;
	assign amt_zero = (amount == '0);
	assign avail_cur = avail_f(rd_w, wr_w, empty_q, cap_w);
	// Read position moved forward by a non-negative amount, used by peek, discard and shift.
	assign fwd_w = wrap_f(rd_w + amt_mag, cap_w);

	assign cfg_w = WW'(cfg_wr_data);
	always_comb begin
		if (cfg_wr_data == '0) begin
			cap_limited = CW'(1);
		end else if (cfg_w > WW'(MAX_DEPTH)) begin
			cap_limited = CW'(MAX_DEPTH);
		end else begin
			cap_limited = cfg_wr_data;
		end
	end

	always_comb begin
		rd_n    = rd_w;
		wr_n    = wr_w;
		fill_n  = fill_w;
		empty_n = empty_q;
		err     = 1'b0;
		we_c    = 1'b0;
		re_c    = 1'b0;
		addr_w  = rd_w;
		case (command)
			rsrb_pkg::CMD_CLEAR: begin
				rd_n    = '0;
				wr_n    = '0;
				fill_n  = '0;
				empty_n = 1'b1;
			end
			rsrb_pkg::CMD_ADD: begin
				if (avail_cur >= cap_w) begin
					err = 1'b1;
				end else begin
					we_c    = 1'b1;
					addr_w  = wr_w;
					wr_n    = wrap_f(wr_w + WW'(1), cap_w);
					empty_n = 1'b0;
					if (fill_w < cap_w) begin
						fill_n = fill_w + WW'(1);
					end
				end
			end
			rsrb_pkg::CMD_REMOVE: begin
				if (empty_q) begin
					err = 1'b1;
				end else begin
					re_c   = 1'b1;
					addr_w = rd_w;
					rd_n   = wrap_f(rd_w + WW'(1), cap_w);
					if (rd_n == wr_w) begin
						empty_n = 1'b1;
					end
				end
			end
			rsrb_pkg::CMD_PEEK: begin
				if (amt_neg || amt_mag >= avail_cur) begin
					err = 1'b1;
				end else begin
					re_c   = 1'b1;
					addr_w = fwd_w;
				end
			end
			rsrb_pkg::CMD_DISCARD: begin
				if (amt_neg || amt_zero || amt_mag > avail_cur) begin
					err = 1'b1;
				end else begin
					rd_n = fwd_w;
					if (fwd_w == wr_w) begin
						empty_n = 1'b1;
					end
				end
			end
			rsrb_pkg::CMD_REWIND: begin
				if (amt_neg || amt_mag > cap_w - avail_cur) begin
					err = 1'b1;
				end else begin
					rd_n = (amt_mag > rd_w) ? rd_w + cap_w - amt_mag : rd_w - amt_mag;
					if (!amt_zero) begin
						empty_n = 1'b0;
					end
				end
			end
			rsrb_pkg::CMD_SHIFT: begin
				if (amt_mag > cap_w) begin
					err = 1'b1;
				end else if (amt_neg) begin
					rd_n = ((rd_w < amt_mag) ? rd_w + cap_w : rd_w) - amt_mag;
				end else begin
					rd_n = fwd_w;
				end
			end
			rsrb_pkg::CMD_STATUS: begin
			end
			default: begin
			end
		endcase
	end

	assign avail_new = avail_f(rd_n, wr_n, empty_n, cap_w);

	assign issue          = in_valid && can_issue;
	assign info.err       = err;
	assign info.rd_mem    = re_c;
	assign info.zero      = (addr_w >= fill_w);
	assign info.available = avail_new[CW-1:0];
	assign info.is_empty  = empty_n;
	assign info.is_full   = (rd_n == wr_n) && !empty_n;

	assign mem_we    = issue && we_c;
	assign mem_re    = issue && re_c;
	assign mem_addr  = addr_w[AW-1:0];
	assign mem_wdata = sample_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CW'(CAP_RST);
			rd_q    <= '0;
			wr_q    <= '0;
			fill_q  <= '0;
			empty_q <= 1'b1;
		end else if (cfg_wr_en) begin
			// A new capacity also empties the ring.
			cap_q   <= cap_limited;
			rd_q    <= '0;
			wr_q    <= '0;
			fill_q  <= '0;
			empty_q <= 1'b1;
		end else if (issue) begin
			rd_q    <= rd_n[AW-1:0];
			wr_q    <= wr_n[AW-1:0];
			fill_q  <= fill_n[CW-1:0];
			empty_q <= empty_n;
		end
	end

	`RSRB_ASSERT(a_fill_in_range, WW'(fill_q) <= WW'(cap_q))
	`RSRB_ASSERT(a_pos_in_range, (WW'(rd_q) < WW'(cap_q)) && (WW'(wr_q) < WW'(cap_q)))
	`RSRB_ASSERT(a_wr_tracks_fill, (WW'(fill_q) >= WW'(cap_q)) || (WW'(wr_q) == WW'(fill_q)))
	`RSRB_ASSERT_NEXT(a_clear_empties, issue && !cfg_wr_en && (command == rsrb_pkg::CMD_CLEAR), empty_q && (fill_q == '0) && (rd_q == '0) && (wr_q == '0))

endmodule

[src/rsrb_resp.sv]
`timescale 1ns / 1ps
module rsrb_resp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  issue,
	input  rsrb_pkg::rsp_info_t                   info,
	input  logic [rsrb_pkg::SAMPLE_W-1:0]         rdata,
	input  logic                                  out_ready,
	output logic                                  can_issue,
	output logic                                  out_valid,
	output logic signed [rsrb_pkg::SAMPLE_W-1:0]  sample_out,
	output logic                                  error,
	output logic [rsrb_pkg::CAP_W-1:0]            available,
	output logic                                  is_empty,
	output logic                                  is_full
);

	logic                s1_valid_s1;
	rsrb_pkg::rsp_info_t info_s1;
	logic                out_valid_q;
	logic                advance;

	assign advance   = !out_valid_q || out_ready;
	// The store read data only changes on a new issue, so it holds while stage 1 waits.
	assign can_issue = !s1_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				s1_valid_s1 <= 1'b1;
			end else if (advance) begin
				s1_valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= s1_valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			info_s1 <= info;
		end
		if (advance && s1_valid_s1) begin
			sample_out <= (info_s1.rd_mem && !info_s1.zero && !info_s1.err) ? rdata : '0;
			error      <= info_s1.err;
			available  <= info_s1.available;
			is_empty   <= info_s1.is_empty;
			is_full    <= info_s1.is_full;
		end
	end

	assign out_valid = out_valid_q;

endmodule

[src/rewindable_sample_ring_buffer.sv]
`timescale 1ns / 1ps
// Ring buffer of signed 16-bit samples with a runtime capacity, taking one command word per
// cycle while in_ready is high and returning one result word for each accepted command
// through the stage-1 register, which holds the read data of the single-port sample store,
// and a registered output stage. Clear and a capacity write need no clearing pass: a fill
// count marks entries written since the last clear, and entries beyond it read as zero.
module rewindable_sample_ring_buffer #(
	parameter int MAX_DEPTH = 1024,
	localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [rsrb_pkg::CAP_W-1:0]            cfg_wr_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [rsrb_pkg::CMD_W-1:0]            command,
	input  logic signed [rsrb_pkg::SAMPLE_W-1:0]  sample_in,
	input  logic signed [rsrb_pkg::AMT_W-1:0]     amount,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [rsrb_pkg::SAMPLE_W-1:0]  sample_out,
	output logic                                  error,
	output logic [rsrb_pkg::CAP_W-1:0]            available,
	output logic                                  is_empty,
	output logic                                  is_full
);

	logic                          can_issue;
	logic                          issue;
	rsrb_pkg::rsp_info_t           info;
	logic                          mem_we;
	logic                          mem_re;
	logic [AW-1:0]                 mem_addr;
	logic [rsrb_pkg::SAMPLE_W-1:0] mem_wdata;
	logic [rsrb_pkg::SAMPLE_W-1:0] mem_rdata;

	assign in_ready = can_issue;

	rsrb_ctrl #(
		.MAX_DEPTH(MAX_DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.can_issue  (can_issue),
		.command    (command),
		.sample_in  (sample_in),
		.amount     (amount),
		.issue      (issue),
		.info       (info),
		.mem_we     (mem_we),
		.mem_re     (mem_re),
		.mem_addr   (mem_addr),
		.mem_wdata  (mem_wdata)
	);

	rsrb_store #(
		.MAX_DEPTH(MAX_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.re   (mem_re),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	rsrb_resp u_resp (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (issue),
		.info      (info),
		.rdata     (mem_rdata),
		.out_ready (out_ready),
		.can_issue (can_issue),
		.out_valid (out_valid),
		.sample_out(sample_out),
		.error     (error),
		.available (available),
		.is_empty  (is_empty),
		.is_full   (is_full)
	);

endmodule
